@@ rtl/auto_ranging_light_dimmer_assert.svh @@
// Assertion macros for the checker file of the light dimmer.
// Depends on nothing; included by the checker module.
`ifndef AUTO_RANGING_LIGHT_DIMMER_ASSERT_SVH
`define AUTO_RANGING_LIGHT_DIMMER_ASSERT_SVH

// A property that must hold at every edge outside reset.
`define ARD_ASSERT_HOLD(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// An implication checked at every edge outside reset.
`define ARD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// An implication whose consequent is checked in the cycle after the antecedent.
`define ARD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/ard_pkg.sv @@
// Shared types, constants and the duty table of the light dimmer.
// Depends on nothing; imported by every module of the block but the checker.
`default_nettype none

package ard_pkg;

   // Field widths.
   localparam int SAMPLE_W = 12;
   localparam int PCT_W    = 7;
   localparam int DUTY_W   = 13;

   // Divider: numerator is 100 times a sample difference, quotient fits 7 bits.
   localparam int NUM_W      = 19;
   localparam int DIV_STEPS  = 7;
   localparam int DIV_CNT_W  = 3;

   // Scaling: target times adjust, then divide by 100 through a reciprocal.
   localparam int PROD_W      = 14;
   localparam int SCALED_W    = 28;
   localparam int RECIP_SHIFT = 20;
   localparam int RECIP_100   = 10486;

   // Percent and PWM constants.
   localparam int PCT_SCALE    = 100;
   localparam int PWM_FULL     = 8191;
   localparam int SMALL_SPREAD = 10;
   localparam int ADJ_DEFAULT  = 50;
   localparam int ADJ_MIN      = 5;
   localparam int ADJ_MAX      = 100;
   localparam int TARGET_RESET = 100;
   localparam int LOW_RESET    = 4095;

   // Queue between the front and the back.
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = 1;
   localparam int Q_CNT_W = 2;

   // One classified sample as it waits for the back.
   typedef struct packed {
      logic [SAMPLE_W-1:0] diff;
      logic [SAMPLE_W-1:0] spread;
      logic                narrow;
   } q_item_type;

   // Sequencer of the back.
   typedef enum logic [2:0] {
      BK_IDLE,
      BK_DIV,
      BK_CLAMP,
      BK_MUL,
      BK_RECIP,
      BK_EMIT
   } back_state_type;

   // Duty for each brightness percent: floor(percent * 8191 / 100).
   localparam int DUTY_LUT_DEPTH = 1 << PCT_W;
   typedef logic [DUTY_W-1:0] duty_lut_type [0:DUTY_LUT_DEPTH-1];

   function automatic duty_lut_type make_duty_lut();
      duty_lut_type lut;
      for (int i = 0; i < DUTY_LUT_DEPTH; i++) begin
         lut[i] = DUTY_W'((i * PWM_FULL) / PCT_SCALE);
      end
      return lut;
   endfunction

   localparam duty_lut_type DUTY_LUT = make_duty_lut();

endpackage

`default_nettype wire

@@ rtl/ard_front.sv @@
// Front of the light dimmer: takes samples, tracks the marks, classifies.
// Depends on ard_pkg; feeds ard_queue.
`default_nettype none

module ard_front import ard_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [SAMPLE_W-1:0] in_sample,
   output logic                push_valid,
   input  logic                push_ready,
   output q_item_type          push_item
);

   logic [SAMPLE_W-1:0] low_ff, low_in;
   logic [SAMPLE_W-1:0] high_ff, high_in;
   logic                take;

   // A transaction is taken whenever the queue has room.
   assign in_ready   = push_ready;
   assign push_valid = in_valid;
   assign take       = in_valid && push_ready;

   // Marks are updated with the sample before they are used.
   always_comb begin
      low_in  = (in_sample < low_ff)  ? in_sample : low_ff;
      high_in = (in_sample > high_ff) ? in_sample : high_ff;
   end

   // Classify: distance below the high mark, spread, and small-spread flag.
   always_comb begin
      push_item.diff   = high_in - in_sample;
      push_item.spread = high_in - low_in;
      push_item.narrow = (push_item.spread <= SAMPLE_W'(SMALL_SPREAD));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff  <= SAMPLE_W'(LOW_RESET);
         high_ff <= '0;
      end else if (take) begin
         low_ff  <= low_in;
         high_ff <= high_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/ard_queue.sv @@
// Short queue of classified samples between front and back.
// Depends on ard_pkg for the item type and depth.
`default_nettype none

module ard_queue import ard_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push_valid,
   output logic       push_ready,
   input  q_item_type push_item,
   output logic       pop_valid,
   input  logic       pop_ready,
   output q_item_type pop_item
);

   q_item_type         entry_ff [0:Q_DEPTH-1];
   logic [Q_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [Q_CNT_W-1:0] count_ff;
   logic               do_push, do_pop;

   assign push_ready = (count_ff != Q_CNT_W'(Q_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Storage needs no reset; the count says what is valid.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + Q_PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + Q_PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + Q_CNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - Q_CNT_W'(1);
         end
      end
   end

endmodule

`default_nettype wire

@@ rtl/ard_back.sv @@
// Back of the light dimmer: divider, clamp, scaling and the output register.
// Depends on ard_pkg; fed by ard_queue.
`default_nettype none

module ard_back import ard_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   output logic              q_ready,
   input  q_item_type        q_item,
   input  logic [PCT_W-1:0]  target_pct,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [PCT_W-1:0]  out_adjust_pct,
   output logic [PCT_W-1:0]  out_brightness_pct,
   output logic [DUTY_W-1:0] out_duty
);

   back_state_type state_ff, state_in;

   logic [NUM_W-1:0]     rem_ff, rem_in;
   logic [SAMPLE_W-1:0]  div_ff, div_in;
   logic                 narrow_ff, narrow_in;
   logic [PCT_W-1:0]     quo_ff, quo_in;
   logic [DIV_CNT_W-1:0] bit_ff, bit_in;
   logic [PCT_W-1:0]     adj_ff, adj_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [SCALED_W-1:0]  scaled_ff, scaled_in;

   logic                 valid_ff;
   logic [PCT_W-1:0]     adj_out_ff, bright_out_ff;
   logic [DUTY_W-1:0]    duty_out_ff;

   logic                 pop, div_step, emit;
   logic [NUM_W-1:0]     shifted;
   logic [PCT_W-1:0]     tgt_sat;
   logic [PCT_W-1:0]     bright;

   // Sequencer outputs.
   always_comb begin
      pop      = (state_ff == BK_IDLE) && q_valid;
      div_step = (state_ff == BK_DIV);
      emit     = (state_ff == BK_EMIT) && (!valid_ff || out_ready);
   end

   assign q_ready = (state_ff == BK_IDLE);

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               state_in = BK_DIV;
            end
         end
         BK_DIV: begin
            if (bit_ff == '0) begin
               state_in = BK_CLAMP;
            end
         end
         BK_CLAMP: state_in = BK_MUL;
         BK_MUL:   state_in = BK_RECIP;
         BK_RECIP: state_in = BK_EMIT;
         BK_EMIT: begin
            if (emit) begin
               state_in = BK_IDLE;
            end
         end
         default:  state_in = BK_IDLE;
      endcase
   end

   // A target above 100 percent is used as 100.
   assign tgt_sat = (target_pct > PCT_W'(PCT_SCALE)) ? PCT_W'(PCT_SCALE) : target_pct;

   // Divisor aligned with the quotient bit under test.
   assign shifted = NUM_W'(div_ff) << bit_ff;

   // Brightness is the product times the reciprocal of 100, shifted down.
   assign bright = scaled_ff[RECIP_SHIFT +: PCT_W];

   // Datapath: restoring divide one quotient bit a cycle, then clamp and scale.
   always_comb begin
      rem_in    = rem_ff;
      div_in    = div_ff;
      narrow_in = narrow_ff;
      quo_in    = quo_ff;
      bit_in    = bit_ff;
      adj_in    = adj_ff;
      prod_in   = prod_ff;
      scaled_in = scaled_ff;
      if (pop) begin
         rem_in    = NUM_W'(q_item.diff) * NUM_W'(PCT_SCALE);
         div_in    = q_item.spread;
         narrow_in = q_item.narrow;
         quo_in    = '0;
         bit_in    = DIV_CNT_W'(DIV_STEPS - 1);
      end
      if (div_step) begin
         if (rem_ff >= shifted) begin
            rem_in         = rem_ff - shifted;
            quo_in[bit_ff] = 1'b1;
         end
         bit_in = bit_ff - DIV_CNT_W'(1);
      end
      if (state_ff == BK_CLAMP) begin
         if (narrow_ff) begin
            adj_in = PCT_W'(ADJ_DEFAULT);
         end else if (quo_ff < PCT_W'(ADJ_MIN)) begin
            adj_in = PCT_W'(ADJ_MIN);
         end else if (quo_ff > PCT_W'(ADJ_MAX)) begin
            adj_in = PCT_W'(ADJ_MAX);
         end else begin
            adj_in = quo_ff;
         end
      end
      if (state_ff == BK_MUL) begin
         prod_in = PROD_W'(tgt_sat) * PROD_W'(adj_ff);
      end
      if (state_ff == BK_RECIP) begin
         scaled_in = SCALED_W'(prod_ff) * SCALED_W'(RECIP_100);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff    <= rem_in;
      div_ff    <= div_in;
      narrow_ff <= narrow_in;
      quo_ff    <= quo_in;
      bit_ff    <= bit_in;
      adj_ff    <= adj_in;
      prod_ff   <= prod_in;
      scaled_ff <= scaled_in;
   end

   // Output register: holds a result until the transaction completes.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (emit) begin
         valid_ff <= 1'b1;
      end else if (out_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         adj_out_ff    <= adj_ff;
         bright_out_ff <= bright;
         duty_out_ff   <= DUTY_LUT[bright];
      end
   end

   assign out_valid          = valid_ff;
   assign out_adjust_pct     = adj_out_ff;
   assign out_brightness_pct = bright_out_ff;
   assign out_duty           = duty_out_ff;

endmodule

`default_nettype wire

@@ rtl/auto_ranging_light_dimmer.sv @@
// A sample is queued, popped by the back, divided by its seven-step divider, clamped,
// put through two multiply stages and looked up in the duty table before its result
// is registered; the back takes no new sample until it has emitted the last result.
// A two-entry queue lets up to two further samples wait while the back is busy
// or a result is held; once it is full, acceptance stops. Reset is synchronous:
// marks go to 4095 and 0, the target to 100, the queue empties, nothing pends.
`default_nettype none

module auto_ranging_light_dimmer import ard_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [11:0] sample, [15:12] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [6:0] adjust_pct, [13:7] brightness_pct,
                                    // [26:14] duty, [31:27] zero
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [6:0]  csr_data     // target_pct
);

   logic [PCT_W-1:0]  target_ff;
   logic              push_valid, push_ready;
   q_item_type        push_item;
   logic              pop_valid, pop_ready;
   q_item_type        pop_item;
   logic [PCT_W-1:0]  adjust_pct, brightness_pct;
   logic [DUTY_W-1:0] duty;

   // Target register; writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= PCT_W'(TARGET_RESET);
      end else if (csr_valid) begin
         target_ff <= csr_data;
      end
   end

   ard_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_sample  (req_tdata[SAMPLE_W-1:0]),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   ard_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   ard_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (pop_valid),
      .q_ready            (pop_ready),
      .q_item             (pop_item),
      .target_pct         (target_ff),
      .out_valid          (rsp_tvalid),
      .out_ready          (rsp_tready),
      .out_adjust_pct     (adjust_pct),
      .out_brightness_pct (brightness_pct),
      .out_duty           (duty)
   );

   // Result fields packed from the lowest bit up.
   assign rsp_tdata = {5'b0, duty, brightness_pct, adjust_pct};

endmodule

`default_nettype wire

@@ rtl/ard_checker.sv @@
// Port-level checks on the light dimmer's result channel, bound to the top.
// Depends on auto_ranging_light_dimmer_assert.svh and the top level.
`default_nettype none
`include "auto_ranging_light_dimmer_assert.svh"

module ard_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   logic [6:0]  adj_f, bright_f;
   logic [12:0] duty_f;

   // Result fields as packed on the data bus.
   assign adj_f    = rsp_tdata[6:0];
   assign bright_f = rsp_tdata[13:7];
   assign duty_f   = rsp_tdata[26:14];

   // Adjust stays within its clamp limits.
   `ARD_ASSERT_IMPL(a_adjust_range, clock, reset, rsp_tvalid, (adj_f >= 7'd5) && (adj_f <= 7'd100), "adjust_pct out of range")

   // Brightness never exceeds the adjust factor, since the target is used as at most 100.
   `ARD_ASSERT_IMPL(a_bright_le_adjust, clock, reset, rsp_tvalid, bright_f <= adj_f, "brightness above adjust")

   // Duty is zero exactly when brightness is zero.
   `ARD_ASSERT_IMPL(a_duty_zero, clock, reset, rsp_tvalid, (duty_f == 13'd0) == (bright_f == 7'd0), "duty zero mismatch")

   // A stalled result transaction holds its data.
   `ARD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result changed")

endmodule

bind auto_ranging_light_dimmer ard_checker u_checker (.*);

`default_nettype wire

@@ test/auto_ranging_light_dimmer_test.sv @@
// Self-checking testbench for the auto-ranging light dimmer.
// It predicts each result in a scoreboard class and drives the sample and result channels with random idling.
// Depends on ard_pkg and the auto_ranging_light_dimmer module only.
`timescale 1ns / 1ps

module auto_ranging_light_dimmer_test;
   import ard_pkg::*;

   localparam int CLOCK_PERIOD  = 10;
   localparam int IDLE_PERCENT  = 11;
   localparam int SETTLE_CYCLES = 20;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_PHASES = 7;
   localparam int PHASE_ITEMS   = 178;

   // One result as the block should present it.
   typedef struct {
      logic [PCT_W-1:0]  adjust;
      logic [PCT_W-1:0]  brightness;
      logic [DUTY_W-1:0] duty;
   } dimmer_level_type;

   // Tracks the marks and the target, predicts each result and checks it in order.
   class dimmer_scoreboard;
      logic [SAMPLE_W-1:0] low_mark  = SAMPLE_W'(LOW_RESET);
      logic [SAMPLE_W-1:0] high_mark = '0;
      logic [PCT_W-1:0]    target    = PCT_W'(TARGET_RESET);
      dimmer_level_type    expected_levels [$];
      int                  samples_seen = 0;
      int                  levels_checked = 0;
      int                  errors = 0;

      function void set_target(logic [PCT_W-1:0] value);
         target = value;
      endfunction

      // Update the marks with an accepted sample and queue the level it should produce.
      function void note_sample(logic [SAMPLE_W-1:0] sample);
         int unsigned      spread;
         int unsigned      adj;
         int unsigned      tgt;
         int unsigned      bright;
         dimmer_level_type level;
         if (sample < low_mark) low_mark = sample;
         if (sample > high_mark) high_mark = sample;
         spread = high_mark - low_mark;
         if (spread <= SMALL_SPREAD) begin
            adj = ADJ_DEFAULT;
         end else begin
            adj = (PCT_SCALE * (high_mark - sample)) / spread;
            if (adj < ADJ_MIN) adj = ADJ_MIN;
            if (adj > ADJ_MAX) adj = ADJ_MAX;
         end
         // Targets above full scale are saturated when used.
         tgt = (target > PCT_SCALE) ? PCT_SCALE : target;
         bright = (tgt * adj) / PCT_SCALE;
         level.adjust     = PCT_W'(adj);
         level.brightness = PCT_W'(bright);
         level.duty       = DUTY_W'((bright * PWM_FULL) / PCT_SCALE);
         expected_levels.push_back(level);
         samples_seen++;
      endfunction

      // Compare one accepted result transaction with the oldest expected level.
      function void check_result(logic [31:0] data);
         dimmer_level_type want;
         logic [PCT_W-1:0]  got_adjust;
         logic [PCT_W-1:0]  got_brightness;
         logic [DUTY_W-1:0] got_duty;
         got_adjust     = data[6:0];
         got_brightness = data[13:7];
         got_duty       = data[26:14];
         if (expected_levels.size() == 0) begin
            $display("%0t: unexpected result transaction, got 0x%08h", $time, data);
            errors++;
            return;
         end
         want = expected_levels.pop_front();
         levels_checked++;
         if (got_adjust !== want.adjust) begin
            $display("%0t: adjust_pct expected %0d, got %0d", $time, want.adjust, got_adjust);
            errors++;
         end
         if (got_brightness !== want.brightness) begin
            $display("%0t: brightness_pct expected %0d, got %0d",
                     $time, want.brightness, got_brightness);
            errors++;
         end
         if (got_duty !== want.duty) begin
            $display("%0t: duty expected %0d, got %0d", $time, want.duty, got_duty);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;    // [11:0] sample, [15:12] zero
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // [6:0] adjust_pct, [13:7] brightness_pct, [26:14] duty
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [6:0]  csr_data = '0;     // target_pct

   dimmer_scoreboard sb = new;
   bit               steady = 1'b0;
   int               cycle_count = 0;
   int               targets_used = 1;

   auto_ranging_light_dimmer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // The result side stalls at random except during the steady stretch.
   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
   end

   // Every accepted result transaction is checked against the prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_result(rsp_tdata);
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results still expected",
                  cycle_count, sb.expected_levels.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Offer one sample; valid stays high after acceptance unless the next one idles first.
   task automatic send_sample(input logic [SAMPLE_W-1:0] sample);
      while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0000, sample};
      do @(posedge clock); while (!req_tready);
      sb.note_sample(sample);
   endtask

   // Wait until every expected result has arrived, then let the block settle.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.expected_levels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write the target register; only called while the block is idle.
   task automatic write_target(input logic [PCT_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      sb.set_target(value);
      csr_valid <= 1'b0;
      @(posedge clock);
      targets_used++;
   endtask

   // Mostly uniform readings, with some at or next to the extremes.
   function automatic logic [SAMPLE_W-1:0] pick_sample();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 5) return '0;
      if (pick < 10) return '1;
      if (pick < 14) return SAMPLE_W'($urandom_range(0, 15));
      if (pick < 18) return SAMPLE_W'($urandom_range(4080, 4095));
      return SAMPLE_W'($urandom_range(0, 4095));
   endfunction

   initial begin
      logic [PCT_W-1:0] phase_target;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset target: small spread up to its boundary, then both ends of the adjust range.
      send_sample(12'd2048);
      send_sample(12'd2053);
      send_sample(12'd2058);
      send_sample(12'd2059);
      send_sample(12'd2048);
      send_sample(12'd2053);
      send_sample(12'd0);
      send_sample(12'd4095);
      send_sample(12'd4095);
      send_sample(12'd0);
      send_sample(12'd2047);
      send_sample(12'd1);
      send_sample(12'd4094);
      send_sample(12'd100);
      drain();

      // A target above full scale must behave as full scale; a zero target follows.
      write_target(7'd127);
      send_sample(12'd0);
      send_sample(12'd4095);
      send_sample(12'd2048);
      drain();
      write_target(7'd101);
      send_sample(12'd1024);
      send_sample(12'd3071);
      drain();
      write_target(7'd0);
      send_sample(12'd0);
      send_sample(12'd2730);
      drain();

      // Random phases, each at its own target; one runs without any idling.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: phase_target = 7'd1;
            1: phase_target = 7'd100;
            2: phase_target = 7'd127;
            3: phase_target = 7'd0;
            default: phase_target = PCT_W'($urandom_range(0, 127));
         endcase
         write_target(phase_target);
         steady = (phase == 2);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            send_sample(pick_sample());
         end
         drain();
         steady = 1'b0;
      end

      if (sb.expected_levels.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, sb.expected_levels.size());
         sb.errors++;
      end
      $display("Run drove %0d sensor samples under %0d target settings.",
               sb.samples_seen, targets_used);
      $display("It checked %0d dimmer results and found %0d mismatches.",
               sb.levels_checked, sb.errors);
      if (sb.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
